// ----- rtl/core/crc16fg_pkg.sv -----
`default_nettype none

package crc16fg_pkg;

  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcTop  = 16'h8000;
  localparam logic [15:0] CrcInit = 16'h0000;

  localparam logic ModeGenerate = 1'b0;
  localparam logic ModeCheck    = 1'b1;

  typedef struct packed {
    logic [15:0] crc_value;
    logic        crc_match;
    logic        too_short;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CrcTop) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/crc16_frame_generate_check_top.sv -----
`default_nettype none

// Channel   | Dir | Handshake                     | Payload
// s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata byte_value, tuser mode, tlast last_byte
// m_axis    | out | m_axis_tvalid / m_axis_tready | tdata crc_value, tuser {too_short, crc_match}
//
// One byte per cycle while no result stalls a last byte; a byte reaches the frame logic
// in the cycle after its transaction, and a last byte's result is registered when it advances.
// The byte-wide CRC update is a single xor network between input and result registers.
// Synchronous reset clears frame state and both valid flags.
// A stalled result only holds back a last byte; other bytes keep flowing.

module crc16_frame_generate_check_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] byte_value
  input  wire logic        s_axis_tuser,  // [0] mode
  input  wire logic        s_axis_tlast,  // last_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // [15:0] crc_value
  output logic [1:0]       m_axis_tuser   // [0] crc_match, [1] too_short
);
  import crc16fg_pkg::*;

  logic       in_valid;
  logic       in_mode;
  logic [7:0] in_byte;
  logic       in_last;
  logic       advance;
  result_t    result;
  result_t    out_reg;

  assign advance       = in_valid && (!in_last || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_mode <= s_axis_tuser;
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  crc16fg_core u_core (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .mode       (in_mode),
    .byte_value (in_byte),
    .last_byte  (in_last),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_reg <= result;
    end
  end

  assign m_axis_tdata = out_reg.crc_value;
  assign m_axis_tuser = {out_reg.too_short, out_reg.crc_match};

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(advance && in_last && m_axis_tvalid && !m_axis_tready))
    else $error("result overwritten while stalled");

  a_short_is_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 16'h0000 && !m_axis_tuser[0])
    else $error("short frame with non-zero crc or match");

  a_ready_only_when_free: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> in_valid && in_last && m_axis_tvalid)
    else $error("input stalled without pending result");

  a_result_follows_last: assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> m_axis_tvalid)
    else $error("last byte gave no result");

endmodule

`default_nettype wire

// ----- rtl/core/crc16fg_core.sv -----
`default_nettype none

module crc16fg_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 advance,
  input  wire logic                 mode,
  input  wire logic [7:0]           byte_value,
  input  wire logic                 last_byte,
  output crc16fg_pkg::result_t      result
);
  import crc16fg_pkg::*;

  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  held0, held0_next;
  logic [7:0]  held1, held1_next;
  logic [1:0]  held_count, held_count_next;
  logic        frame_mode, frame_mode_next;
  logic        in_frame, in_frame_next;

  logic [15:0] crc_base;
  logic [1:0]  count_base;
  logic [7:0]  crc_in;
  logic [15:0] crc_step;

  always_comb begin
    frame_mode_next = in_frame ? frame_mode : mode;
    crc_base        = in_frame ? running_crc : CrcInit;
    count_base      = in_frame ? held_count : 2'd0;
    crc_in          = (frame_mode_next == ModeGenerate) ? byte_value : held0;
    crc_step        = crc_byte(crc_base, crc_in);

    running_crc_next = crc_base;
    held0_next       = held0;
    held1_next       = held1;
    held_count_next  = count_base;
    if (frame_mode_next == ModeGenerate) begin
      running_crc_next = crc_step;
    end else if (count_base == 2'd2) begin
      running_crc_next = crc_step;
      held0_next       = held1;
      held1_next       = byte_value;
    end else begin
      if (count_base[0]) begin
        held1_next = byte_value;
      end else begin
        held0_next = byte_value;
      end
      held_count_next = count_base + 2'd1;
    end
    in_frame_next = !last_byte;
  end

  always_comb begin
    result.crc_value = running_crc_next;
    result.crc_match = 1'b0;
    result.too_short = 1'b0;
    if (frame_mode_next == ModeCheck) begin
      if (held_count_next != 2'd2) begin
        result.too_short = 1'b1;
      end else begin
        result.crc_match = (running_crc_next == {held1_next, held0_next});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= CrcInit;
      held0       <= 8'h00;
      held1       <= 8'h00;
      held_count  <= 2'd0;
      frame_mode  <= ModeGenerate;
      in_frame    <= 1'b0;
    end else if (advance) begin
      running_crc <= running_crc_next;
      held0       <= held0_next;
      held1       <= held1_next;
      held_count  <= held_count_next;
      frame_mode  <= frame_mode_next;
      in_frame    <= in_frame_next;
    end
  end

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import crc16fg_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int ByteTarget = 1650;
  localparam int CalmTail   = 250;

  typedef logic [7:0] byte_q_t[$];
  typedef enum int {KeepMode, FlipMode, RandMode} later_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  crc16_frame_generate_check_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [15:0] acc_crc    = CrcInit;
  logic [7:0]  tail_bytes[2] = '{8'h00, 8'h00};
  logic [1:0]  tail_cnt   = 2'd0;
  logic        cur_mode   = ModeGenerate;
  logic        mid_frame  = 1'b0;
  result_t     frame_results_q[$];

  bit src_idle  = 1'b0;
  bit sink_idle = 1'b0;
  int error_count = 0;
  int cycles = 0;
  int n_bytes = 0;
  int n_gen_frames = 0;
  int n_check_frames = 0;
  int n_matched = 0;
  int n_short = 0;
  int n_results = 0;

  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  function automatic byte_q_t with_trailer(input byte_q_t payload);
    byte_q_t     framed;
    logic [15:0] c;
    framed = payload;
    c = CrcInit;
    foreach (payload[i]) c = crc16_next(c, payload[i]);
    framed.push_back(c[7:0]);
    framed.push_back(c[15:8]);
    return framed;
  endfunction

  function automatic logic [7:0] rand_byte();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic predict_byte(input logic mode_in, input logic [7:0] b, input logic is_last);
    result_t     r;
    logic [15:0] stored;
    n_bytes++;
    if (!mid_frame) begin
      acc_crc   = CrcInit;
      tail_cnt  = 2'd0;
      cur_mode  = mode_in;
      mid_frame = 1'b1;
    end
    if (cur_mode == ModeGenerate) begin
      acc_crc = crc16_next(acc_crc, b);
    end else if (tail_cnt == 2'd2) begin
      acc_crc = crc16_next(acc_crc, tail_bytes[0]);
      tail_bytes[0] = tail_bytes[1];
      tail_bytes[1] = b;
    end else begin
      tail_bytes[tail_cnt[0]] = b;
      tail_cnt = tail_cnt + 2'd1;
    end
    if (is_last) begin
      mid_frame   = 1'b0;
      r.crc_value = acc_crc;
      r.crc_match = 1'b0;
      r.too_short = 1'b0;
      if (cur_mode == ModeGenerate) begin
        n_gen_frames++;
      end else begin
        n_check_frames++;
        if (tail_cnt < 2'd2) begin
          r.too_short = 1'b1;
          n_short++;
        end else begin
          stored = {tail_bytes[1], tail_bytes[0]};
          r.crc_match = (stored == acc_crc);
          if (r.crc_match) n_matched++;
        end
      end
      frame_results_q.push_back(r);
    end
  endtask

  // called at a rising edge; returns at the edge where the byte is taken
  task automatic send_byte(input logic mode_in, input logic [7:0] b, input logic is_last);
    if (src_idle && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= mode_in;
    s_axis_tlast  <= is_last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_byte(mode_in, b, is_last);
  endtask

  task automatic send_frame(input logic first_mode, input byte_q_t data,
                            input later_mode_t later);
    logic m;
    foreach (data[i]) begin
      m = first_mode;
      if (i > 0) begin
        case (later)
          FlipMode: m = ~first_mode;
          RandMode: m = 1'($urandom_range(0, 1));
          default:  m = first_mode;
        endcase
      end
      send_byte(m, data[i], i == data.size() - 1);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (frame_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_generate_frames();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    send_frame(ModeGenerate, {8'h00}, KeepMode);
    send_frame(ModeGenerate, {8'hFF}, KeepMode);
    send_frame(ModeGenerate, {8'h31, 8'h32, 8'h33}, KeepMode);
    wait_drained();
  endtask

  task automatic test_check_frames();
    src_idle  = 1'b0;
    sink_idle = 1'b1;
    send_frame(ModeCheck, {8'hFF}, KeepMode);
    send_frame(ModeCheck, {8'h00, 8'h00}, KeepMode);
    send_frame(ModeCheck, {8'hA5, 8'h5A}, KeepMode);
    send_frame(ModeCheck, with_trailer({8'h31, 8'h32}), KeepMode);
    wait_drained();
  endtask

  task automatic test_mode_switch_mid_frame();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    send_frame(ModeGenerate, {8'h80, 8'h01, 8'hFE}, FlipMode);
    send_frame(ModeCheck, with_trailer({8'h7F, 8'h00}), FlipMode);
    wait_drained();
  endtask

  task automatic test_random_frames();
    byte_q_t     data;
    logic        fmode;
    int          len;
    int          sel;
    int          pos;
    logic [2:0]  bit_pos;
    while (n_bytes < ByteTarget) begin
      if (n_bytes >= ByteTarget - CalmTail) begin
        src_idle  = 1'b0;
        sink_idle = 1'b0;
      end else begin
        src_idle  = ($urandom_range(0, 3) != 0);
        sink_idle = ($urandom_range(0, 3) != 0);
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      data.delete();
      fmode = ($urandom_range(0, 9) < 4) ? ModeGenerate : ModeCheck;
      if (fmode == ModeGenerate) begin
        repeat (len) data.push_back(rand_byte());
      end else begin
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
          data.push_back(rand_byte());
        end else begin
          repeat ($urandom_range(0, len)) data.push_back(rand_byte());
          data = with_trailer(data);
          if (sel >= 7) begin
            pos = $urandom_range(0, data.size() - 1);
            bit_pos = 3'($urandom_range(0, 7));
            data[pos][bit_pos] ^= 1'b1;
          end
        end
      end
      send_frame(fmode, data, RandMode);
    end
    wait_drained();
  endtask

  always begin
    @(posedge clk);
    if (sink_idle && $urandom_range(0, 4) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    m_axis_tready <= 1'b1;
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (frame_results_q.size() == 0) begin
        $error("unexpected result transaction: crc_value %h", m_axis_tdata);
        error_count++;
      end else begin
        exp_r = frame_results_q.pop_front();
        if (m_axis_tdata !== exp_r.crc_value) begin
          $error("crc_value: expected %h, got %h", exp_r.crc_value, m_axis_tdata);
          error_count++;
        end
        if (m_axis_tuser[0] !== exp_r.crc_match) begin
          $error("crc_match: expected %b, got %b", exp_r.crc_match, m_axis_tuser[0]);
          error_count++;
        end
        if (m_axis_tuser[1] !== exp_r.too_short) begin
          $error("too_short: expected %b, got %b", exp_r.too_short, m_axis_tuser[1]);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timed out after %0d cycles", cycles);
      $display("[crc16_frame_generate_check_top] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_generate_frames();
    test_check_frames();
    test_mode_switch_mid_frame();
    test_random_frames();
    repeat (8) @(posedge clk);
    $display("%0d bytes in %0d generate and %0d check frames, %0d results checked",
             n_bytes, n_gen_frames, n_check_frames, n_results);
    $display("check frames: %0d matching CRC, %0d under two bytes", n_matched, n_short);
    if (error_count == 0) begin
      $display("[crc16_frame_generate_check_top] OK");
    end else begin
      $display("[crc16_frame_generate_check_top] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
